// ----- hw/rtl/lpmr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared codes, constants and types of the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

   // request opcodes
   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_URGENT = 3'd1;
   localparam logic [2:0] OP_DATA   = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // response status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_SMALL   = 3'd2;
   localparam logic [2:0] ST_NOSPACE = 3'd3;
   localparam logic [2:0] ST_NOLOCK  = 3'd4;

   // register indexes (byte address bit 2)
   localparam logic REG_RING_WORDS = 1'b0;
   localparam logic REG_LOCK       = 1'b1;

   localparam logic [10:0] RING_WORDS_RESET = 11'd1024;
   localparam logic        LOCK_RESET       = 1'b1;

   localparam int WORD_BYTES = 4;
   localparam int WORD_SHIFT = $clog2(WORD_BYTES);

   typedef struct packed {
      logic [10:0] ring_words;
      logic        lock;
      logic        clear;
   } cfg_type;

endpackage

// ----- hw/rtl/lpmr_ram.sv -----
// ----------------------------------------------------------------------------
// lpmr_ram
// Ring word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpmr_ram #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/lpmr_csr.sv -----
// ----------------------------------------------------------------------------
// lpmr_csr
// Configuration registers behind the bus port: ring size and urgent lock.
// ----------------------------------------------------------------------------
module lpmr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output lpmr_pkg::cfg_type cfg
);
   import lpmr_pkg::*;

   logic [10:0] ring_words_ff;
   logic [10:0] ring_words_in;
   logic        lock_ff;
   logic        lock_in;
   logic        wr_transfer;

   assign pready      = 1'b1;
   assign wr_transfer = psel & penable & pwrite;

   always_comb begin
      ring_words_in = ring_words_ff;
      lock_in       = lock_ff;
      if (wr_transfer) begin
         if (paddr[2] == REG_RING_WORDS) begin
            ring_words_in = pwdata[10:0];
         end else begin
            lock_in = pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_words_ff <= RING_WORDS_RESET;
         lock_ff       <= LOCK_RESET;
      end else begin
         ring_words_ff <= ring_words_in;
         lock_ff       <= lock_in;
      end
   end

   always_comb begin
      if (paddr[2] == REG_RING_WORDS) begin
         prdata = {21'd0, ring_words_ff};
      end else begin
         prdata = {31'd0, lock_ff};
      end
   end

   // a ring size write empties the ring
   assign cfg.ring_words = ring_words_ff;
   assign cfg.lock       = lock_ff;
   assign cfg.clear      = wr_transfer & (paddr[2] == REG_RING_WORDS);

endmodule

// ----- hw/rtl/lpmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer of the message ring: pointers, space check, header and word
// transfers to and from the word store, and the response register.
// ----------------------------------------------------------------------------
module lpmr_ctrl #(
   parameter int RING_WORDS    = 1024,
   parameter int MAX_MSG_WORDS = 63,
   localparam int AW = $clog2(RING_WORDS)
) (
   input  logic              clock,
   input  logic              reset,
   input  lpmr_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_opcode,
   input  logic [7:0]        req_byte_len,
   input  logic [7:0]        req_max_len,
   input  logic [31:0]       req_data_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic              rsp_word_valid,
   output logic [31:0]       rsp_word_out,
   output logic [7:0]        rsp_msg_len,
   output logic              rsp_last,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [31:0]       mem_wr_data,
   output logic              mem_rd_en,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [31:0]       mem_rd_data
);
   import lpmr_pkg::*;

   localparam int WCW = $clog2(MAX_MSG_WORDS + 1);
   localparam int CW  = (AW + 2 > 9) ? AW + 2 : 9;
   localparam int SW  = (AW + 1 > 11) ? AW + 1 : 11;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RHDR = 2'd2;
   localparam logic [1:0] S_RDAT = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [2:0]     op_ff, op_in;
   logic [7:0]     len_ff, len_in;
   logic [7:0]     mlen_ff, mlen_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  tail_ff, tail_in;
   logic [AW-1:0]  fill_ff, fill_in;
   logic [WCW-1:0] pending_ff, pending_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [WCW-1:0] cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_word_valid_ff, rsp_word_valid_in;
   logic [31:0]    rsp_word_ff, rsp_word_in;
   logic [7:0]     rsp_len_ff, rsp_len_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [SW-1:0]  size_raw;
   logic [AW:0]    ring_n;
   logic           slot_free;
   logic [6:0]     wr_words;
   logic [CW-1:0]  n_c, head_c, tail_c, free_c, need_c, span_c, base_c;
   logic [2:0]     wr_status;
   logic [AW-1:0]  wr_base;
   logic [7:0]     hdr_len;
   logic [6:0]     hdr_words_raw;
   logic [WCW-1:0] hdr_words;
   logic [AW-1:0]  head_next;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [AW:0] n);
      logic [AW:0] q;
      q = {1'b0, p} + {{AW{1'b0}}, 1'b1};
      wrap_inc = (q == n) ? '0 : q[AW-1:0];
   endfunction

   // ring size clamped to 2..RING_WORDS
   always_comb begin
      size_raw = SW'(cfg.ring_words);
      if (size_raw < SW'(2)) begin
         ring_n = (AW + 1)'(2);
      end else if (size_raw > SW'(RING_WORDS)) begin
         ring_n = (AW + 1)'(RING_WORDS);
      end else begin
         ring_n = size_raw[AW:0];
      end
   end

   // write start: space check and new pointer
   always_comb begin
      wr_words = 7'(({1'b0, len_ff} + 9'(WORD_BYTES - 1)) >> WORD_SHIFT);
      n_c      = CW'(ring_n);
      head_c   = CW'(head_ff);
      tail_c   = CW'(tail_ff);
      if (head_ff == tail_ff) begin
         free_c = n_c;
      end else if (head_ff > tail_ff) begin
         free_c = head_c - tail_c;
      end else begin
         free_c = n_c - tail_c + head_c;
      end
      span_c = CW'(wr_words) + CW'(1);
      need_c = CW'(wr_words) + CW'(2);
      if (op_ff == OP_URGENT && !cfg.lock) begin
         wr_status = ST_NOLOCK;
      end else if (wr_words > 7'(MAX_MSG_WORDS) || free_c < need_c) begin
         wr_status = ST_NOSPACE;
      end else begin
         wr_status = ST_OK;
      end
      if (op_ff == OP_URGENT) begin
         base_c = head_c + n_c - span_c;
      end else begin
         base_c = tail_c + span_c;
      end
      if (base_c >= n_c) begin
         base_c = base_c - n_c;
      end
      wr_base = (op_ff == OP_URGENT) ? base_c[AW-1:0] : tail_ff;
   end

   // read: header decode
   always_comb begin
      hdr_len       = mem_rd_data[7:0];
      hdr_words_raw = 7'(({1'b0, hdr_len} + 9'(WORD_BYTES - 1)) >> WORD_SHIFT);
      if (hdr_words_raw > 7'(MAX_MSG_WORDS)) begin
         hdr_words = WCW'(MAX_MSG_WORDS);
      end else begin
         hdr_words = hdr_words_raw[WCW-1:0];
      end
      head_next = wrap_inc(head_ff, ring_n);
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      len_in            = len_ff;
      mlen_in           = mlen_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      fill_in           = fill_ff;
      pending_in        = pending_ff;
      ptr_in            = ptr_ff;
      cnt_in            = cnt_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_word_valid_in = rsp_word_valid_ff;
      rsp_word_in       = rsp_word_ff;
      rsp_len_in        = rsp_len_ff;
      rsp_last_in       = rsp_last_ff;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = fill_ff;
      mem_wr_data       = req_data_word;
      mem_rd_en         = 1'b0;
      mem_rd_addr       = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_opcode == OP_DATA) begin
                  // stray words with no open message are dropped
                  if (pending_ff != '0) begin
                     mem_wr_en  = 1'b1;
                     fill_in    = wrap_inc(fill_ff, ring_n);
                     pending_in = pending_ff - WCW'(1);
                  end
               end else if (req_opcode inside {OP_WRITE, OP_URGENT, OP_READ, OP_CLEAR}) begin
                  op_in      = req_opcode;
                  len_in     = req_byte_len;
                  mlen_in    = req_max_len;
                  pending_in = '0;
                  state_in   = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = ST_OK;
               rsp_word_valid_in = 1'b0;
               rsp_word_in       = '0;
               rsp_len_in        = '0;
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
               case (op_ff)
                  OP_WRITE, OP_URGENT: begin
                     rsp_status_in = wr_status;
                     if (wr_status == ST_OK) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wr_base;
                        mem_wr_data = {24'd0, len_ff};
                        if (op_ff == OP_URGENT) begin
                           head_in = base_c[AW-1:0];
                        end else begin
                           tail_in = base_c[AW-1:0];
                        end
                        fill_in    = wrap_inc(wr_base, ring_n);
                        pending_in = wr_words[WCW-1:0];
                     end
                  end
                  OP_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                     fill_in = '0;
                  end
                  OP_READ: begin
                     if (head_ff == tail_ff) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // header fetch; the status is set in S_RHDR once the header word is back
                        rsp_valid_in = rsp_valid_ff && !rsp_ready;
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = head_ff;
                        state_in     = S_RHDR;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  end
               endcase
            end
         end
         S_RHDR: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_word_valid_in = 1'b0;
               rsp_word_in       = '0;
               if (mlen_ff < hdr_len) begin
                  rsp_status_in = ST_SMALL;
                  rsp_len_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_len_in    = hdr_len;
                  rsp_last_in   = (hdr_words == '0);
                  len_in        = hdr_len;
                  if (hdr_words == '0) begin
                     head_in  = head_next;
                     state_in = S_IDLE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_next;
                     ptr_in      = wrap_inc(head_next, ring_n);
                     cnt_in      = hdr_words;
                     state_in    = S_RDAT;
                  end
               end
            end
         end
         S_RDAT: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = ST_OK;
               rsp_word_valid_in = 1'b1;
               rsp_word_in       = mem_rd_data;
               rsp_len_in        = len_ff;
               rsp_last_in       = (cnt_ff == WCW'(1));
               cnt_in            = cnt_ff - WCW'(1);
               if (cnt_ff == WCW'(1)) begin
                  head_in  = ptr_ff;
                  state_in = S_IDLE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_ff;
                  ptr_in      = wrap_inc(ptr_ff, ring_n);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg.clear) begin
         head_in    = '0;
         tail_in    = '0;
         fill_in    = '0;
         pending_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      len_ff            <= len_in;
      mlen_ff           <= mlen_in;
      ptr_ff            <= ptr_in;
      cnt_ff            <= cnt_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_word_valid_ff <= rsp_word_valid_in;
      rsp_word_ff       <= rsp_word_in;
      rsp_len_ff        <= rsp_len_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_word_valid = rsp_word_valid_ff;
   assign rsp_word_out   = rsp_word_ff;
   assign rsp_msg_len    = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- hw/rtl/length_prefixed_message_ring_top.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_top
// Ring of variable-length messages, each a length header word plus its data
// words, with stream request and response channels and a register port.
// ----------------------------------------------------------------------------
// Timing: a data word transfer is taken every cycle while the block is idle. A
// write start, urgent write start or clear is accepted and then, once the
// response register is free, does the space check and header write (or the
// clear) and gives one response. A read is accepted, fetches the header from
// the word store and checks it, then streams its data words at one per cycle
// while the response register is free; the registered read data of the word
// store sets the header step. The response sits in an output register, so the
// next request is accepted while the last response of the previous one waits.
// Opcodes 5 to 7 are dropped. Writing the ring size register empties the ring.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_top #(
   parameter int RING_WORDS    = 1024,
   parameter int MAX_MSG_WORDS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // byte_len[7:0], max_len[15:8], data_word[47:16]
   input  logic [2:0]  req_tuser,    // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // word_out[31:0], msg_len[39:32]
   output logic [3:0]  rsp_tuser,    // status[2:0], word_valid[3]
   output logic        rsp_tlast,    // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lpmr_pkg::*;

   localparam int AW = $clog2(RING_WORDS);

   cfg_type       cfg;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;
   logic [2:0]    rsp_status;
   logic          rsp_word_valid;
   logic [31:0]   rsp_word_out;
   logic [7:0]    rsp_msg_len;

   lpmr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lpmr_ram #(
      .DEPTH (RING_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lpmr_ctrl #(
      .RING_WORDS    (RING_WORDS),
      .MAX_MSG_WORDS (MAX_MSG_WORDS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_opcode     (req_tuser),
      .req_byte_len   (req_tdata[7:0]),
      .req_max_len    (req_tdata[15:8]),
      .req_data_word  (req_tdata[47:16]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_word_valid (rsp_word_valid),
      .rsp_word_out   (rsp_word_out),
      .rsp_msg_len    (rsp_msg_len),
      .rsp_last       (rsp_tlast),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   assign rsp_tdata = {rsp_msg_len, rsp_word_out};
   assign rsp_tuser = {rsp_word_valid, rsp_status};

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed message ring. A directed table
// covers the corner cases, then random traffic under several ring sizes and
// lock settings is checked against a behavioral model of the ring, with random
// stalls on both stream channels outside the steady phases.
// ----------------------------------------------------------------------------
module tb;
   import lpmr_pkg::*;

   localparam int RING_DEPTH    = 1024;
   localparam int RING_AW       = $clog2(RING_DEPTH);
   localparam int MSG_WORDS_MAX = 63;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 20;
   localparam int NUM_ROWS      = 25;
   localparam int ROW_AW        = $clog2(NUM_ROWS);
   localparam int NUM_PHASES    = 10;
   localparam int PH_AW         = $clog2(NUM_PHASES);
   localparam int PHASE_ITEMS   = 36;
   localparam logic [2:0]  OP_SPARE5 = 3'd5;
   localparam logic [2:0]  OP_SPARE6 = 3'd6;
   localparam logic [2:0]  OP_SPARE7 = 3'd7;
   localparam logic [31:0] WORD_STEP = 32'h9e37_79b9;

   typedef struct packed {
      logic [2:0]  status;
      logic        word_valid;
      logic [31:0] word;
      logic [7:0]  len;
      logic        last;
   } ring_rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  blen;
      logic [7:0]  mlen;
      logic [31:0] word;
      logic [7:0]  reps;
      logic        typed;
      logic [2:0]  status;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // byte_len[7:0], max_len[15:8], data_word[47:16]
   logic [2:0]  req_tuser;    // opcode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // word_out[31:0], msg_len[39:32]
   logic [3:0]  rsp_tuser;    // status[2:0], word_valid[3]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   length_prefixed_message_ring_top #(
      .RING_WORDS    (RING_DEPTH),
      .MAX_MSG_WORDS (MSG_WORDS_MAX)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the ring
   logic [31:0]  ring_mem [RING_DEPTH];
   bit           mem_written [RING_DEPTH];
   int           head_w, tail_w, fill_w, open_words;
   logic [10:0]  ring_cfg;
   logic         lock_cfg;
   ring_rsp_type outstanding [$];

   int           mismatches, results_seen, requests_done, settings_done, cycle_count;
   bit           steady;
   ring_rsp_type seen_rsp, want_rsp;
   plan_row_type plan [NUM_ROWS];

   logic [31:0] ring_plan [NUM_PHASES] = '{32'd1024, 32'd2, 32'd0, 32'd2047, 32'd16,
                                           32'd5, 32'd3, 32'd64, 32'd1, 32'd333};
   logic [31:0] lock_plan [NUM_PHASES] = '{32'd1, 32'd1, 32'd0, 32'd1, 32'd1,
                                           32'd0, 32'd1, 32'd1, 32'd1, 32'd0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [RING_AW-1:0] ring_ix(input int p);
      return p[RING_AW-1:0];
   endfunction

   function automatic int eff_size();
      int n;
      n = int'(ring_cfg);
      if (n < 2) n = 2;
      if (n > RING_DEPTH) n = RING_DEPTH;
      return n;
   endfunction

   function automatic int free_words();
      int n;
      n = eff_size();
      if (head_w == tail_w) return n;
      if (head_w > tail_w) return head_w - tail_w;
      return n - tail_w + head_w;
   endfunction

   // an open message may only be cut short where its remaining words hold known data
   function automatic bit pending_written();
      int n, i;
      n = eff_size();
      for (i = 0; i < open_words; i++) begin
         if (!mem_written[ring_ix((fill_w + i) % n)]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void queue_rsp(logic [2:0] st, logic wv, logic [31:0] w,
                                     logic [7:0] len, logic last);
      ring_rsp_type r;
      r.status     = st;
      r.word_valid = wv;
      r.word       = w;
      r.len        = len;
      r.last       = last;
      outstanding.push_back(r);
   endfunction

   function automatic void apply_request(logic [2:0] op, logic [7:0] blen, logic [7:0] mlen,
                                         logic [31:0] dw, bit keep);
      int n, words, span, base, p, len, i;
      logic [2:0] st;
      n = eff_size();
      if (op == OP_DATA) begin
         if (open_words != 0) begin
            ring_mem[ring_ix(fill_w)]    = dw;
            mem_written[ring_ix(fill_w)] = 1'b1;
            fill_w                       = (fill_w + 1) % n;
            open_words                   = open_words - 1;
         end
         return;
      end
      if (op > OP_CLEAR) return;
      open_words = 0;
      if (op == OP_WRITE || op == OP_URGENT) begin
         words = (int'(blen) + WORD_BYTES - 1) / WORD_BYTES;
         span  = words + 1;
         if (op == OP_URGENT && lock_cfg != 1'b1) st = ST_NOLOCK;
         else if (words > MSG_WORDS_MAX) st = ST_NOSPACE;
         else if (free_words() < span + 1) st = ST_NOSPACE;
         else begin
            if (op == OP_URGENT) begin
               head_w = (head_w + n - span) % n;
               base   = head_w;
            end else begin
               base   = tail_w;
               tail_w = (tail_w + span) % n;
            end
            ring_mem[ring_ix(base)]    = {24'd0, blen};
            mem_written[ring_ix(base)] = 1'b1;
            fill_w                     = (base + 1) % n;
            open_words                 = words;
            st                         = ST_OK;
         end
         if (keep) queue_rsp(st, 1'b0, 32'd0, 8'd0, 1'b1);
         return;
      end
      if (op == OP_CLEAR) begin
         head_w = 0;
         tail_w = 0;
         fill_w = 0;
         if (keep) queue_rsp(ST_OK, 1'b0, 32'd0, 8'd0, 1'b1);
         return;
      end
      if (head_w == tail_w) begin
         if (keep) queue_rsp(ST_EMPTY, 1'b0, 32'd0, 8'd0, 1'b1);
         return;
      end
      len   = int'(ring_mem[ring_ix(head_w)][7:0]);
      words = (len + WORD_BYTES - 1) / WORD_BYTES;
      if (int'(mlen) < len) begin
         if (keep) queue_rsp(ST_SMALL, 1'b0, 32'd0, 8'd0, 1'b1);
         return;
      end
      if (words > MSG_WORDS_MAX) words = MSG_WORDS_MAX;
      if (keep) queue_rsp(ST_OK, 1'b0, 32'd0, len[7:0], words == 0);
      p = (head_w + 1) % n;
      for (i = 0; i < words; i++) begin
         if (keep) queue_rsp(ST_OK, 1'b1, ring_mem[ring_ix(p)], len[7:0], i + 1 == words);
         p = (p + 1) % n;
      end
      head_w = p;
   endfunction

   function automatic plan_row_type make_row(logic [2:0] op, logic [7:0] blen,
                                             logic [7:0] mlen, logic [31:0] word,
                                             logic [7:0] reps, logic typed,
                                             logic [2:0] st);
      plan_row_type r;
      r.op     = op;
      r.blen   = blen;
      r.mlen   = mlen;
      r.word   = word;
      r.reps   = reps;
      r.typed  = typed;
      r.status = st;
      return r;
   endfunction

   task automatic send_req(input logic [2:0] op, input logic [7:0] blen, input logic [7:0] mlen,
                           input logic [31:0] dw, input bit typed, input logic [2:0] st);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {dw, mlen, blen};
      do @(posedge clock); while (!req_tready);
      apply_request(op, blen, mlen, dw, !typed);
      if (typed) queue_rsp(st, 1'b0, 32'd0, 8'd0, 1'b1);
      requests_done++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding.size() != 0) @(posedge clock);
      // trailing data word transfers give no response, so let them drain
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_set(input logic idx, input logic [31:0] value);
      logic [31:0] mask, got;
      mask = (idx == REG_RING_WORDS) ? 32'h0000_07ff : 32'h0000_0001;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_RING_WORDS) begin
         ring_cfg   = value[10:0];
         head_w     = 0;
         tail_w     = 0;
         fill_w     = 0;
         open_words = 0;
      end else begin
         lock_cfg = value[0];
      end
      // read it back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== (value & mask)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d readback: want %h got %h", idx, value & mask, got);
      end
      settings_done++;
   endtask

   task automatic run_random(input int quota);
      int done_cnt, n, roll, fit, occ, hdr;
      logic [2:0] op;
      logic [7:0] blen, mlen;
      done_cnt = 0;
      while (done_cnt < quota) begin
         n    = eff_size();
         blen = 8'($urandom_range(0, 255));
         mlen = 8'($urandom_range(0, 255));
         if (open_words != 0 && !($urandom_range(0, 99) < 5 && pending_written())) begin
            op = OP_DATA;
         end else begin
            roll = $urandom_range(0, 99);
            occ  = n - free_words();
            if (roll < 4) op = OP_DATA;
            else if (roll < 7) op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
            else if (roll < 10) op = OP_CLEAR;
            else if (roll < 15 + (occ * 70) / n) op = OP_READ;
            else if ($urandom_range(0, 3) == 0) op = OP_URGENT;
            else op = OP_WRITE;
         end
         if (op == OP_WRITE || op == OP_URGENT) begin
            fit = (n - 2) * WORD_BYTES;
            if (fit > 40) fit = 40;
            roll = $urandom_range(0, 99);
            if (roll < 70) blen = 8'($urandom_range(0, fit));
            else if (roll < 85) blen = 8'($urandom_range(0, 252));
            else if (roll < 93) blen = 8'd252;
            else blen = 8'($urandom_range(253, 255));
         end
         if (op == OP_READ && head_w != tail_w) begin
            hdr  = int'(ring_mem[ring_ix(head_w)][7:0]);
            roll = $urandom_range(0, 99);
            if (roll < 15) mlen = 8'(hdr);
            else if (roll < 30 && hdr > 0) mlen = 8'(hdr - 1);
            else if (roll < 70) mlen = 8'd255;
         end
         // stray data words and spare opcodes are dropped by the block
         if (op <= OP_CLEAR && !(op == OP_DATA && open_words == 0)) done_cnt++;
         send_req(op, blen, mlen, $urandom(), 1'b0, ST_OK);
      end
   endtask

   // response side: random stall before each transfer, none in the steady phases
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         @(negedge clock);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = {rsp_tuser[2:0], rsp_tuser[3], rsp_tdata[31:0], rsp_tdata[39:32], rsp_tlast};
         results_seen++;
         if (outstanding.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: st=%0d wv=%0b word=%h len=%0d last=%0b",
                        seen_rsp.status, seen_rsp.word_valid, seen_rsp.word,
                        seen_rsp.len, seen_rsp.last);
         end else begin
            want_rsp = outstanding.pop_front();
            if (want_rsp !== seen_rsp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d: want st=%0d wv=%0b word=%h len=%0d last=%0b",
                           results_seen, want_rsp.status, want_rsp.word_valid,
                           want_rsp.word, want_rsp.len, want_rsp.last);
                  $display("response %0d: got  st=%0d wv=%0b word=%h len=%0d last=%0b",
                           results_seen, seen_rsp.status, seen_rsp.word_valid,
                           seen_rsp.word, seen_rsp.len, seen_rsp.last);
               end
            end
         end
      end
   end

   initial begin
      int r, k, ph;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_WRITE;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cycle_count = 0;
      mismatches  = 0;
      results_seen  = 0;
      requests_done = 0;
      settings_done = 0;
      steady      = 1'b0;
      ring_cfg    = RING_WORDS_RESET;
      lock_cfg    = LOCK_RESET;
      head_w      = 0;
      tail_w      = 0;
      fill_w      = 0;
      open_words  = 0;

      plan[0]  = make_row(OP_READ,   8'd0,   8'd255, 32'h0,         8'd1,  1'b1, ST_EMPTY);
      plan[1]  = make_row(OP_DATA,   8'd0,   8'd0,   32'hffff_ffff, 8'd1,  1'b0, ST_OK);
      plan[2]  = make_row(OP_WRITE,  8'd255, 8'd0,   32'h0,         8'd1,  1'b1, ST_NOSPACE);
      plan[3]  = make_row(OP_WRITE,  8'd0,   8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[4]  = make_row(OP_READ,   8'd0,   8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[5]  = make_row(OP_WRITE,  8'd252, 8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[6]  = make_row(OP_DATA,   8'd0,   8'd0,   32'h0,         8'd63, 1'b0, ST_OK);
      plan[7]  = make_row(OP_READ,   8'd0,   8'd251, 32'h0,         8'd1,  1'b1, ST_SMALL);
      plan[8]  = make_row(OP_READ,   8'd0,   8'd255, 32'h0,         8'd1,  1'b0, ST_OK);
      plan[9]  = make_row(OP_WRITE,  8'd5,   8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[10] = make_row(OP_DATA,   8'd0,   8'd0,   32'h0,         8'd1,  1'b0, ST_OK);
      plan[11] = make_row(OP_DATA,   8'd0,   8'd0,   32'hffff_ffff, 8'd1,  1'b0, ST_OK);
      plan[12] = make_row(OP_URGENT, 8'd3,   8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[13] = make_row(OP_DATA,   8'd0,   8'd0,   32'ha5a5_a5a5, 8'd1,  1'b0, ST_OK);
      plan[14] = make_row(OP_READ,   8'd0,   8'd255, 32'h0,         8'd1,  1'b0, ST_OK);
      plan[15] = make_row(OP_READ,   8'd0,   8'd255, 32'h0,         8'd1,  1'b0, ST_OK);
      plan[16] = make_row(OP_SPARE5, 8'd255, 8'd255, 32'hffff_ffff, 8'd1,  1'b0, ST_OK);
      plan[17] = make_row(OP_SPARE6, 8'd0,   8'd0,   32'h0,         8'd1,  1'b0, ST_OK);
      plan[18] = make_row(OP_SPARE7, 8'd255, 8'd255, 32'hffff_ffff, 8'd1,  1'b0, ST_OK);
      plan[19] = make_row(OP_CLEAR,  8'd0,   8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[20] = make_row(OP_READ,   8'd0,   8'd255, 32'h0,         8'd1,  1'b1, ST_EMPTY);
      plan[21] = make_row(OP_WRITE,  8'd12,  8'd0,   32'h0,         8'd1,  1'b1, ST_OK);
      plan[22] = make_row(OP_DATA,   8'd0,   8'd0,   32'h1234_5678, 8'd1,  1'b0, ST_OK);
      // cut short after one word: the rest comes from what the ring held before
      plan[23] = make_row(OP_READ,   8'd0,   8'd255, 32'h0,         8'd1,  1'b0, ST_OK);
      plan[24] = make_row(OP_WRITE,  8'd4,   8'd0,   32'h0,         8'd1,  1'b1, ST_OK);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < NUM_ROWS; r++) begin
         for (k = 0; k < int'(plan[r[ROW_AW-1:0]].reps); k++) begin
            send_req(plan[r[ROW_AW-1:0]].op, plan[r[ROW_AW-1:0]].blen,
                     plan[r[ROW_AW-1:0]].mlen, plan[r[ROW_AW-1:0]].word + k * WORD_STEP,
                     plan[r[ROW_AW-1:0]].typed, plan[r[ROW_AW-1:0]].status);
         end
      end
      settle();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         csr_set(REG_RING_WORDS, ring_plan[ph[PH_AW-1:0]]);
         csr_set(REG_LOCK, lock_plan[ph[PH_AW-1:0]]);
         steady = (ph % 3 == 1);
         run_random(PHASE_ITEMS);
         settle();
      end

      $display("ring run: %0d request transfers, %0d response transfers checked",
               requests_done, results_seen);
      $display("ring run: %0d register settings, %0d mismatches", settings_done, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
